// File: rtl/min_distance_point_placement_assert.svh
// Assertion macros for the point placement block.
`ifndef MIN_DISTANCE_POINT_PLACEMENT_ASSERT_SVH
`define MIN_DISTANCE_POINT_PLACEMENT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MDPP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdpp: same-cycle check failed");
// next-cycle implication
`define MDPP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdpp: next-cycle check failed");
`else
`define MDPP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MDPP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/mdpp_pkg.sv
// Shared types and constants for the point placement block.
package mdpp_pkg;

  localparam int POS_W      = 16;
  localparam int ANG_W      = 16;
  localparam int RAND_W     = 16;
  localparam int IDX_W      = 8;
  localparam int DIST_W     = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int TGT_W      = 9;
  localparam int REJ_W      = 16;
  localparam int DLAT       = 3;   // distance pipe depth

  typedef struct packed {
    logic [RAND_W-1:0] rand_x;
    logic [RAND_W-1:0] rand_y;
    logic [RAND_W-1:0] rand_z;
    logic [RAND_W-1:0] rand_a;
    logic [RAND_W-1:0] rand_b;
    logic [RAND_W-1:0] rand_g;
  } cand_t;

  typedef struct packed {
    logic             accepted;
    logic             timed_out;
    logic [IDX_W-1:0] point_index;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [ANG_W-1:0] angle_a;
    logic [ANG_W-1:0] angle_b;
    logic [ANG_W-1:0] angle_g;
    logic             finished;
  } res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_COUNT    = 3'd0,
    CFG_MIN_DISTANCE_SQ = 3'd1,
    CFG_EXTENT_X        = 3'd2,
    CFG_EXTENT_Y        = 3'd3,
    CFG_EXTENT_Z        = 3'd4,
    CFG_ATTEMPT_LIMIT   = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } dist_status_t;

endpackage

// File: rtl/mdpp_cell.sv
// One storage cell of the rotating point ring.
module mdpp_cell #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] shift_in,
  input  logic [W-1:0] load_in,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_in;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

// File: rtl/mdpp_dist.sv
// Three-stage squared distance compare against the ring head.
module mdpp_dist #(
  parameter int PW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue,
  input  logic [3*PW-1:0]               cand_pt,
  input  logic [3*PW-1:0]               ref_pt,
  input  logic [mdpp_pkg::DIST_W-1:0]   min_distance_sq,
  output mdpp_pkg::dist_status_t        status
);

  logic [PW-1:0]   ca [3];
  logic [PW-1:0]   ra [3];
  logic [PW-1:0]   d1 [3];
  logic [2*PW-1:0] q2 [3];
  logic            v1, v2;
  logic            hit_q, valid_q;
  logic [mdpp_pkg::DIST_W-1:0] sum;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ca[a] = cand_pt[(2-a)*PW +: PW];
      ra[a] = ref_pt[(2-a)*PW +: PW];
    end
  end

  assign sum = mdpp_pkg::DIST_W'(q2[0]) + mdpp_pkg::DIST_W'(q2[1])
             + mdpp_pkg::DIST_W'(q2[2]);

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      d1[a] <= (ca[a] >= ra[a]) ? (ca[a] - ra[a]) : (ra[a] - ca[a]);
      q2[a] <= d1[a] * d1[a];
    end
    hit_q <= (sum < min_distance_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1      <= issue;
      v2      <= v1;
      valid_q <= v2;
    end
  end

  assign status = '{valid: valid_q, hit: hit_q};

endmodule

// File: rtl/min_distance_point_placement.sv
// Top level: minimum-distance 3D point placement by rejection.
//
// Candidate channel (cand_valid/cand_ready/cand): one beat is one draw of six
// 16-bit fractions. Result channel (res_valid/res_ready/res): one beat per
// candidate, in order. Config port (cfg_we/cfg_index/cfg_data) writes one
// register per cycle, no handshake.
// A candidate is scaled in the S_SCALE state, then the stored points rotate
// once around a ring of MAX_POINTS cells past a three-stage distance compare.
// One candidate is in work at a time: a new beat is taken only in S_IDLE,
// after the result of the last one has been issued. Once finished, a beat
// skips the scan and is answered with only finished set.
// The result sits in an output register: a stalled receiver holds it, the
// next candidate is still taken and worked, and it waits only at the end.
// Reset (synchronous, rst) restores config defaults and clears the point
// count, reject count and done flag; ring contents are left as they are,
// since only cells below the point count are ever compared.
module min_distance_point_placement #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mdpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              cand_valid,
  output logic                              cand_ready,
  input  mdpp_pkg::cand_t                   cand,
  output logic                              res_valid,
  input  logic                              res_ready,
  output mdpp_pkg::res_t                    res
);

  `include "min_distance_point_placement_assert.svh"

  // stored coordinate width: COORD_BITS capped at POS_W; scaled values are masked to that width
  localparam int PW = (COORD_BITS < mdpp_pkg::POS_W) ? COORD_BITS : mdpp_pkg::POS_W;
  localparam int CW = $clog2(MAX_POINTS + 1);      // point count
  localparam int IW = $clog2(MAX_POINTS);          // ring slot
  localparam int TW = (CW > mdpp_pkg::TGT_W) ? CW : mdpp_pkg::TGT_W;

  // config registers
  logic [mdpp_pkg::TGT_W-1:0]  target_count;
  logic [mdpp_pkg::DIST_W-1:0] min_distance_sq;
  logic [mdpp_pkg::POS_W-1:0]  extent_x, extent_y, extent_z;
  logic [mdpp_pkg::REJ_W-1:0]  attempt_limit;

  // control and working state
  mdpp_pkg::state_t state, state_next;
  logic [CW-1:0]              step;
  logic [CW-1:0]              placed_count;
  logic [mdpp_pkg::REJ_W-1:0] reject_count;
  logic                       done_flag;
  logic                       dead;      // candidate met a finished block
  logic                       reject;
  mdpp_pkg::cand_t            cand_q;
  logic [mdpp_pkg::POS_W-1:0] pos_x, pos_y, pos_z;

  logic [TW-1:0]              tgt;
  logic                       dead_now;
  logic                       shift_en, issue, fire, load_en;
  logic [CW-1:0]              placed_inc;
  logic [mdpp_pkg::REJ_W-1:0] rej_inc;
  mdpp_pkg::res_t             res_next;
  logic [3*PW-1:0]            new_pt;
  logic [3*PW-1:0]            cell_q [MAX_POINTS];
  mdpp_pkg::dist_status_t     dist_st;

  logic [2*mdpp_pkg::POS_W-1:0] prod_x, prod_y, prod_z;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count    <= mdpp_pkg::TGT_W'(256);
      min_distance_sq <= '0;
      extent_x        <= 16'hFFFF;
      extent_y        <= 16'hFFFF;
      extent_z        <= 16'hFFFF;
      attempt_limit   <= 16'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        mdpp_pkg::CFG_TARGET_COUNT:    target_count    <= cfg_data[mdpp_pkg::TGT_W-1:0];
        mdpp_pkg::CFG_MIN_DISTANCE_SQ: min_distance_sq <= cfg_data;
        mdpp_pkg::CFG_EXTENT_X:        extent_x        <= cfg_data[15:0];
        mdpp_pkg::CFG_EXTENT_Y:        extent_y        <= cfg_data[15:0];
        mdpp_pkg::CFG_EXTENT_Z:        extent_z        <= cfg_data[15:0];
        mdpp_pkg::CFG_ATTEMPT_LIMIT:   attempt_limit   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective target: zero acts as one, clipped at ring size
  always_comb begin
    if (target_count == '0) begin
      tgt = TW'(1);
    end else if (TW'(target_count) > TW'(MAX_POINTS)) begin
      tgt = TW'(MAX_POINTS);
    end else begin
      tgt = TW'(target_count);
    end
  end

  assign dead_now   = done_flag || (TW'(placed_count) >= tgt);
  assign placed_inc = placed_count + CW'(1);
  assign rej_inc    = (reject_count == '1) ? reject_count
                                           : reject_count + mdpp_pkg::REJ_W'(1);

  // ------------------------------------------------------------------ ring
  assign new_pt = {pos_x[PW-1:0], pos_y[PW-1:0], pos_z[PW-1:0]};

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
    mdpp_cell #(.W(3*PW)) u_cell (
      .clk      (clk),
      .shift    (shift_en),
      .load     (load_en && (placed_count[IW-1:0] == IW'(k))),
      .shift_in (cell_q[(k + 1) % MAX_POINTS]),
      .load_in  (new_pt),
      .q        (cell_q[k])
    );
  end

  // head of the ring feeds the compare pipe
  mdpp_dist #(.PW(PW)) u_dist (
    .clk             (clk),
    .rst             (rst),
    .issue           (issue),
    .cand_pt         (new_pt),
    .ref_pt          (cell_q[0]),
    .min_distance_sq (min_distance_sq),
    .status          (dist_st)
  );

  // ------------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdpp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cand_ready = 1'b0;
    shift_en   = 1'b0;
    issue      = 1'b0;
    fire       = 1'b0;
    case (state)
      mdpp_pkg::S_IDLE: begin
        cand_ready = 1'b1;
        if (cand_valid) begin
          state_next = dead_now ? mdpp_pkg::S_RESOLVE : mdpp_pkg::S_SCALE;
        end
      end
      mdpp_pkg::S_SCALE: begin
        state_next = mdpp_pkg::S_SCAN;
      end
      mdpp_pkg::S_SCAN: begin
        // one full turn keeps slot k back at cell k
        shift_en = 1'b1;
        issue    = (step < placed_count);
        if (step == CW'(MAX_POINTS - 1)) begin
          state_next = mdpp_pkg::S_DRAIN;
        end
      end
      mdpp_pkg::S_DRAIN: begin
        if (step == CW'(mdpp_pkg::DLAT - 1)) begin
          state_next = mdpp_pkg::S_RESOLVE;
        end
      end
      mdpp_pkg::S_RESOLVE: begin
        if (!res_valid || res_ready) begin
          fire       = 1'b1;
          state_next = mdpp_pkg::S_IDLE;
        end
      end
      default: state_next = mdpp_pkg::S_IDLE;
    endcase
  end

  assign load_en = fire && !dead && !reject;

  // result of the current candidate
  always_comb begin
    res_next = '0;
    if (dead) begin
      res_next.finished = 1'b1;
    end else begin
      res_next.pos_x   = pos_x;
      res_next.pos_y   = pos_y;
      res_next.pos_z   = pos_z;
      res_next.angle_a = cand_q.rand_a;
      res_next.angle_b = cand_q.rand_b;
      res_next.angle_g = cand_q.rand_g;
      if (reject) begin
        if (rej_inc >= attempt_limit) begin
          res_next.timed_out = 1'b1;
          res_next.finished  = 1'b1;
        end
      end else begin
        res_next.accepted    = 1'b1;
        res_next.point_index = mdpp_pkg::IDX_W'(placed_count);
        res_next.finished    = (TW'(placed_inc) >= tgt);
      end
    end
  end

  // ------------------------------------------------------------- datapath
  assign prod_x = extent_x * cand_q.rand_x;
  assign prod_y = extent_y * cand_q.rand_y;
  assign prod_z = extent_z * cand_q.rand_z;

  always_ff @(posedge clk) begin
    if (cand_valid && cand_ready) begin
      cand_q <= cand;
    end
    if (state == mdpp_pkg::S_SCALE) begin
      pos_x <= mdpp_pkg::POS_W'(prod_x[mdpp_pkg::POS_W +: PW]);
      pos_y <= mdpp_pkg::POS_W'(prod_y[mdpp_pkg::POS_W +: PW]);
      pos_z <= mdpp_pkg::POS_W'(prod_z[mdpp_pkg::POS_W +: PW]);
    end
    if (fire) begin
      res <= res_next;
    end
    step <= (state_next != state) ? '0 : step + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed_count <= '0;
      reject_count <= '0;
      done_flag    <= 1'b0;
      dead         <= 1'b0;
      reject       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cand_valid && cand_ready) begin
        dead <= dead_now;
        if (dead_now) begin
          done_flag <= 1'b1;
        end
      end
      if (state == mdpp_pkg::S_SCALE) begin
        reject <= 1'b0;
      end else if (dist_st.valid && dist_st.hit) begin
        reject <= 1'b1;
      end
      if (fire && !dead) begin
        if (reject) begin
          reject_count <= rej_inc;
          if (rej_inc >= attempt_limit) begin
            done_flag <= 1'b1;
          end
        end else begin
          placed_count <= placed_inc;
          reject_count <= '0;
          if (TW'(placed_inc) >= tgt) begin
            done_flag <= 1'b1;
          end
        end
      end
      if (fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ assertions
  `MDPP_ASSERT_IMP(a_acc_not_timeout, clk, rst, res_valid, !(res.accepted && res.timed_out))
  `MDPP_ASSERT_NXT(a_done_sticky, clk, rst, done_flag, done_flag)
  `MDPP_ASSERT_IMP(a_load_in_ring, clk, rst, load_en, (placed_count < CW'(MAX_POINTS)))
  `MDPP_ASSERT_NXT(a_beat_leaves_idle, clk, rst, cand_valid && cand_ready, state != mdpp_pkg::S_IDLE)

endmodule
